### sv/i2ctbm_pkg.sv
// ----------------------------------------------------------------------------
// i2ctbm_pkg
// Shared types, event codes and address helpers for the I2C target byte
// memory: store depth, pointer width and the byte-to-address table.
// ----------------------------------------------------------------------------
package i2ctbm_pkg;

    // store geometry
    localparam int MEM_DEPTH = 256;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int CMD_W     = 3;
    localparam int DATA_W    = 8;
    localparam int BYTE_CODES = 1 << DATA_W;

    // bus event codes
    localparam logic [CMD_W-1:0] EV_WRITE_RECEIVED  = 3'd0;
    localparam logic [CMD_W-1:0] EV_READ_REQUESTED  = 3'd1;
    localparam logic [CMD_W-1:0] EV_READ_PROCESSED  = 3'd2;
    localparam logic [CMD_W-1:0] EV_WRITE_REQUESTED = 3'd3;
    localparam logic [CMD_W-1:0] EV_STOP            = 3'd4;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [DATA_W-1:0] byte_t;
    typedef addr_t addr_lut_t [BYTE_CODES];

    // memory request from the control logic to the store
    typedef struct packed {
        logic  wr_en;
        logic  rd_en;
        addr_t addr;
        byte_t wdata;
    } mem_req_t;

    // address byte to pointer value, reduced modulo the depth at elaboration
    function automatic addr_lut_t build_addr_lut();
        addr_lut_t lut;
        for (int i = 0; i < BYTE_CODES; i++)
        begin
            lut[i] = ADDR_W'(i % MEM_DEPTH);
        end
        return lut;
    endfunction

    localparam addr_lut_t ADDR_LUT = build_addr_lut();

    // pointer advance with wrap at the top of the store
    function automatic addr_t addr_inc(input addr_t a);
        addr_t r;
        if (a == addr_t'(MEM_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = a + addr_t'(1);
        end
        return r;
    endfunction

endpackage

### sv/i2ctbm_ctrl.sv
// ----------------------------------------------------------------------------
// i2ctbm_ctrl
// Address pointer and address-phase flag; turns each accepted bus event into
// at most one memory request for the byte store.
// ----------------------------------------------------------------------------
module i2ctbm_ctrl
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic [i2ctbm_pkg::CMD_W-1:0]  cmd,
    input  i2ctbm_pkg::byte_t             data_in,
    output i2ctbm_pkg::mem_req_t          req,
    output logic                          is_read
);

    i2ctbm_pkg::addr_t ptr_reg;
    i2ctbm_pkg::addr_t ptr_next;
    logic              loaded_reg;
    logic              loaded_next;
    i2ctbm_pkg::addr_t ptr_inc;

    assign ptr_inc = i2ctbm_pkg::addr_inc(ptr_reg);

    // event decode
    always_comb
    begin
        ptr_next    = ptr_reg;
        loaded_next = loaded_reg;
        req.wr_en   = 1'b0;
        req.rd_en   = 1'b0;
        req.addr    = ptr_reg;
        req.wdata   = data_in;
        is_read     = 1'b0;
        case (cmd)
            i2ctbm_pkg::EV_WRITE_RECEIVED:
            begin
                if (!loaded_reg)
                begin
                    ptr_next    = i2ctbm_pkg::ADDR_LUT[data_in];
                    loaded_next = 1'b1;
                end
                else
                begin
                    req.wr_en = accept;
                    ptr_next  = ptr_inc;
                end
            end
            i2ctbm_pkg::EV_READ_REQUESTED:
            begin
                req.rd_en = accept;
                is_read   = 1'b1;
            end
            i2ctbm_pkg::EV_READ_PROCESSED:
            begin
                ptr_next  = ptr_inc;
                req.addr  = ptr_inc;
                req.rd_en = accept;
                is_read   = 1'b1;
            end
            i2ctbm_pkg::EV_WRITE_REQUESTED,
            i2ctbm_pkg::EV_STOP:
            begin
                loaded_next = 1'b0;
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    // pointer state, updated once per transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg    <= '0;
            loaded_reg <= 1'b0;
        end
        else if (accept)
        begin
            ptr_reg    <= ptr_next;
            loaded_reg <= loaded_next;
        end
    end

    // a data byte is only stored once the address phase is over
    a_wr_after_addr: assert property (@(posedge clk) disable iff (!rst_n)
        req.wr_en |-> loaded_reg)
        else $error("store write during address phase");

    // one transaction never both reads and writes the store
    a_no_rd_wr: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.wr_en && req.rd_en))
        else $error("store read and write in the same transaction");

    // the first byte after a re-arm loads the pointer without a store write
    a_addr_load: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !loaded_reg && cmd == i2ctbm_pkg::EV_WRITE_RECEIVED)
        |=> (loaded_reg && ptr_reg == $past(i2ctbm_pkg::ADDR_LUT[data_in])))
        else $error("address byte not loaded into pointer");

endmodule

### sv/i2ctbm_mem.sv
// ----------------------------------------------------------------------------
// i2ctbm_mem
// Byte store with one write or one registered read per cycle. Per-entry valid
// bits, cleared by reset, make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module i2ctbm_mem
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  i2ctbm_pkg::mem_req_t req,
    output i2ctbm_pkg::byte_t    rdata
);

    i2ctbm_pkg::byte_t                   mem [i2ctbm_pkg::MEM_DEPTH];
    logic [i2ctbm_pkg::MEM_DEPTH-1:0]    vld_reg;
    i2ctbm_pkg::byte_t                   q_reg;
    logic                                hit_reg;

    // storage array and registered read
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.addr] <= req.wdata;
        end
        if (req.rd_en)
        begin
            q_reg   <= mem[req.addr];
            hit_reg <= vld_reg[req.addr];
        end
    end

    // written-entry flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (req.wr_en)
        begin
            vld_reg[req.addr] <= 1'b1;
        end
    end

    // never-written entries hold the reset value
    assign rdata = hit_reg ? q_reg : '0;

endmodule

### sv/i2c_target_byte_memory_core.sv
// ----------------------------------------------------------------------------
// i2c_target_byte_memory_core
// Byte memory behind an I2C target: one bus event in, one result out.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------
//   in      | in_valid / in_stall  | cmd[2:0], data_in[7:0]
//   out     | out_valid / out_stall| read_data[7:0], read_valid
//
// one transaction per cycle while in_stall is low; a result appears in the
// cycle after acceptance, set by the registered read of the byte store
// reset clears pointer, address-phase flag and the store's valid bits at once,
// so there is no clearing pass
// in_stall is raised only while a result is held by out_stall
// ----------------------------------------------------------------------------
module i2c_target_byte_memory_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [i2ctbm_pkg::CMD_W-1:0]  cmd,
    input  logic [7:0]                    data_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    read_data,
    output logic                          read_valid
);

    logic                 accept;
    logic                 is_read;
    i2ctbm_pkg::mem_req_t req;
    i2ctbm_pkg::byte_t    mem_rdata;
    logic                 out_valid_reg;
    logic                 is_read_reg;
    i2ctbm_pkg::byte_t    echo_reg;

    // handshake
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    i2ctbm_ctrl u_ctrl
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .cmd     (cmd),
        .data_in (data_in),
        .req     (req),
        .is_read (is_read)
    );

    i2ctbm_mem u_mem
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rdata (mem_rdata)
    );

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            is_read_reg <= is_read;
            echo_reg    <= data_in;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_valid = is_read_reg;
    assign read_data  = is_read_reg ? mem_rdata : echo_reg;

    // every accepted transaction yields a result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid)
        else $error("accepted transaction produced no result");

    // read events are flagged as reads
    a_read_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == i2ctbm_pkg::EV_READ_REQUESTED ||
                    cmd == i2ctbm_pkg::EV_READ_PROCESSED))
        |=> read_valid)
        else $error("read event without read_valid");

    // other events echo the received byte
    a_echo: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cmd != i2ctbm_pkg::EV_READ_REQUESTED &&
                   cmd != i2ctbm_pkg::EV_READ_PROCESSED)
        |=> (!read_valid && read_data == $past(data_in)))
        else $error("non-read event did not echo data_in");

endmodule
